@@ hdl/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int unsigned COORD_BITS  = 10;
  localparam int unsigned DELTA_BITS  = COORD_BITS + 1;
  localparam int unsigned DEC_BITS    = COORD_BITS + 3;
  localparam int unsigned IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((2 * COORD_BITS + 2 + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  // octant minus one
  typedef enum logic [2:0] {
    OCT1 = 3'd0,
    OCT2 = 3'd1,
    OCT3 = 3'd2,
    OCT4 = 3'd3,
    OCT5 = 3'd4,
    OCT6 = 3'd5,
    OCT7 = 3'd6,
    OCT8 = 3'd7
  } oct_e;

  function automatic logic x_is_major(oct_e oct);
    return oct inside {OCT1, OCT4, OCT5, OCT8};
  endfunction

endpackage

@@ hdl/midpoint_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// Eight-octant midpoint line rasterizer, one pixel per step transfer while a line is in progress.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the request. A load transfer (tuser = 0)
// latches both endpoints from tdata, picks the octant and gives no pixel.
// A step transfer (tuser = 1) gives one pixel of the current line, walking
// from the first endpoint to the second; the final pixel carries tlast and
// the rasterizer goes idle. A step while idle gives nothing. A load while
// a line is in progress drops that line.
// Output stream: one pixel per transfer, x, y and the quadrant color code.
// The output is registered: the pixel appears on the output in the cycle after
// its step transfer. Throughput: one transfer per cycle unless the receiver
// stalls; each pixel is one add and compare on the registered line state.
// The single output register frees in the cycle the receiver takes it, so
// s_axis_tready_o is high whenever the output is empty or being taken; a
// stalled receiver holds the pixel and stops the input.
// Reset: returns to idle with the output empty; no line is loaded.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_x, start_y, end_x, end_y
  input  logic [mlr_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // req_type
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // pixel_x, pixel_y, quadrant_color, zero pad
  output logic [mlr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // last_pixel
  output logic                               m_axis_tlast_o
);
  import mlr_pkg::*;

  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  dec_t   dec_q, dec_d;
  delta_t dx_q, dy_q;
  coord_t stop_q;
  oct_e   oct_q;
  logic   busy_q, busy_d;

  logic   out_valid_q, out_valid_d;
  coord_t out_x_q, out_y_q;
  logic [1:0] out_color_q;
  logic   out_last_q;

  logic   s_xfer, is_load, is_step, pix_en;
  coord_t ld_sx, ld_sy, ld_ex, ld_ey;
  delta_t ld_dx, ld_dy;
  logic signed [DELTA_BITS:0] ld_sum;
  oct_e   ld_oct;
  dec_t   dxe, dye;
  logic   last;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign s_xfer  = s_axis_tvalid_i & s_axis_tready_o;
  assign is_load = s_xfer & (s_axis_tuser_i == REQ_LOAD);
  assign is_step = s_xfer & (s_axis_tuser_i == REQ_STEP);
  assign pix_en  = is_step & busy_q;

  assign ld_sx = s_axis_tdata_i[0*COORD_BITS +: COORD_BITS];
  assign ld_sy = s_axis_tdata_i[1*COORD_BITS +: COORD_BITS];
  assign ld_ex = s_axis_tdata_i[2*COORD_BITS +: COORD_BITS];
  assign ld_ey = s_axis_tdata_i[3*COORD_BITS +: COORD_BITS];
  assign ld_dx = $signed({1'b0, ld_ex}) - $signed({1'b0, ld_sx});
  assign ld_dy = $signed({1'b0, ld_ey}) - $signed({1'b0, ld_sy});
  assign ld_sum = $signed({ld_dx[DELTA_BITS-1], ld_dx})
                + $signed({ld_dy[DELTA_BITS-1], ld_dy});

  always_comb begin
    if (!ld_dy[DELTA_BITS-1] && !ld_dx[DELTA_BITS-1]) begin
      ld_oct = (ld_dx > ld_dy) ? OCT8 : OCT7;
    end else if (!ld_dy[DELTA_BITS-1]) begin
      ld_oct = (ld_sum > 0) ? OCT6 : OCT5;
    end else if (ld_dx <= 0) begin
      ld_oct = (ld_dx < ld_dy) ? OCT4 : OCT3;
    end else begin
      ld_oct = (ld_sum < 0) ? OCT2 : OCT1;
    end
  end

  assign dxe  = DEC_BITS'(dx_q);
  assign dye  = DEC_BITS'(dy_q);
  assign last = x_is_major(oct_q) ? (cur_x_q == stop_q) : (cur_y_q == stop_q);

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    dec_d   = dec_q;
    case (oct_q)
      OCT1: begin
        if (dec_q > 0) begin
          dec_d = dec_q - dye - dxe; cur_y_d = cur_y_q - 1'b1;
        end else begin
          dec_d = dec_q - dye;
        end
        cur_x_d = cur_x_q + 1'b1;
      end
      OCT2: begin
        if (dec_q > 0) begin
          dec_d = dec_q + dxe + dye; cur_x_d = cur_x_q + 1'b1;
        end else begin
          dec_d = dec_q + dxe;
        end
        cur_y_d = cur_y_q - 1'b1;
      end
      OCT3: begin
        if (dec_q < 0) begin
          dec_d = dec_q + dxe - dye; cur_x_d = cur_x_q - 1'b1;
        end else begin
          dec_d = dec_q + dxe;
        end
        cur_y_d = cur_y_q - 1'b1;
      end
      OCT4: begin
        if (dec_q < 0) begin
          dec_d = dec_q + dye - dxe; cur_y_d = cur_y_q - 1'b1;
        end else begin
          dec_d = dec_q + dye;
        end
        cur_x_d = cur_x_q - 1'b1;
      end
      OCT5: begin
        if (dec_q < 0) begin
          dec_d = dec_q - dxe - dye; cur_y_d = cur_y_q + 1'b1;
        end else begin
          dec_d = dec_q - dye;
        end
        cur_x_d = cur_x_q - 1'b1;
      end
      OCT6: begin
        if (dec_q < 0) begin
          dec_d = dec_q + dxe + dye; cur_x_d = cur_x_q - 1'b1;
        end else begin
          dec_d = dec_q + dxe;
        end
        cur_y_d = cur_y_q + 1'b1;
      end
      OCT7: begin
        if (dec_q > 0) begin
          dec_d = dec_q + dxe - dye; cur_x_d = cur_x_q + 1'b1;
        end else begin
          dec_d = dec_q + dxe;
        end
        cur_y_d = cur_y_q + 1'b1;
      end
      default: begin
        if (dec_q > 0) begin
          dec_d = dec_q + dye - dxe; cur_y_d = cur_y_q + 1'b1;
        end else begin
          dec_d = dec_q + dye;
        end
        cur_x_d = cur_x_q + 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (is_load) begin
      busy_d = 1'b1;
    end else if (pix_en && last) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s_xfer) begin
      out_valid_d = pix_en;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      cur_x_q <= ld_sx;
      cur_y_q <= ld_sy;
      dec_q   <= '0;
      dx_q    <= ld_dx;
      dy_q    <= ld_dy;
      oct_q   <= ld_oct;
      stop_q  <= x_is_major(ld_oct) ? ld_ex : ld_ey;
    end else if (pix_en) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      dec_q   <= dec_d;
    end
    if (pix_en) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_color_q <= ~oct_q[2:1];
      out_last_q  <= last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ hdl/mlr_checker.sv @@
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks of the midpoint line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mlr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [mlr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [mlr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o
);
  import mlr_pkg::*;

  logic unused_in;
  assign unused_in = ^s_axis_tdata_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("pixel dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("pixel changed while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_LOAD)
    |=> !m_axis_tvalid_o)
    else $error("load transfer produced a pixel");

endmodule

bind midpoint_line_rasterizer_top mlr_checker u_mlr_checker (.*);
